// ===== rtl/bnis_pkg.sv =====
// Package: shared constants, controller states and command/status structs for the box sorter.
`default_nettype none
package bnis_pkg;

  // Fixed field widths of the request and result channels
  localparam int DIM_IN_W  = 16;
  localparam int NUM_OUT_W = 6;

  // Defaults for the top-level parameters
  localparam int MAX_BOXES_DEF = 64;
  localparam int DIM_WIDTH_DEF = 16;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_EMIT_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // latch the arriving box request
    logic rd_pos;     // read the entry just below the insertion point
    logic shift;      // move that entry up one place
    logic place;      // write the new box at the insertion point
    logic emit_rd;    // read the entry at the emit index
    logic emit_load;  // load the result register from the read data
    logic emit_next;  // step the emit index
    logic run_clr;    // end of run: empty the list
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;       // list holds MAX_BOXES entries
    logic cnt_zero;   // list is empty
    logic pos_one;    // insertion point is one above the bottom
    logic fits;       // new box fits inside the entry just read
    logic last;       // latched last-box mark
    logic in_last;    // last-box mark on the incoming request
    logic emit_end;   // emit index is at the top entry
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/bnis_if.sv =====
// Interfaces: box request channel and result channel.
`default_nettype none
interface bnis_box_if;
  import bnis_pkg::*;
  logic                valid;
  logic                ready;
  logic [DIM_IN_W-1:0] dim_a;
  logic [DIM_IN_W-1:0] dim_b;
  logic [DIM_IN_W-1:0] dim_c;
  logic                last_box;

  modport source (output valid, dim_a, dim_b, dim_c, last_box, input ready);
  modport sink   (input valid, dim_a, dim_b, dim_c, last_box, output ready);
endinterface

interface bnis_res_if;
  import bnis_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [NUM_OUT_W-1:0] box_number;
  logic                 final_result;
  logic                 overflow;

  modport source (output valid, box_number, final_result, overflow, input ready);
  modport sink   (input valid, box_number, final_result, overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/bnis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bnis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bnis_ctrl.sv =====
// Controller: state machine sequencing insertion and result emission.
`default_nettype none
module bnis_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire bnis_pkg::sts_t sts,
  output bnis_pkg::cmd_t      cmd
);
  import bnis_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.full) begin
            state_next = sts.in_last ? S_EMIT_RD : S_IDLE;
          end else begin
            state_next = sts.cnt_zero ? S_WRITE : S_READ;
          end
        end
      end
      S_READ:  state_next = S_CMP;
      S_CMP: begin
        if (sts.fits && !sts.pos_one) begin
          state_next = S_READ;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE:     state_next = sts.last ? S_EMIT_RD : S_IDLE;
      S_EMIT_RD:   state_next = S_EMIT_LOAD;
      S_EMIT_LOAD: state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: begin
        if (out_ready) begin
          state_next = sts.emit_end ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_READ:      cmd.rd_pos = 1'b1;
      S_CMP:       cmd.shift = sts.fits;
      S_WRITE:     cmd.place = 1'b1;
      S_EMIT_RD:   cmd.emit_rd = 1'b1;
      S_EMIT_LOAD: cmd.emit_load = 1'b1;
      S_EMIT_WAIT: begin
        out_valid     = 1'b1;
        cmd.emit_next = out_ready && !sts.emit_end;
        cmd.run_clr   = out_ready && sts.emit_end;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bnis_dp.sv =====
// Datapath: box list storage, insertion pointer, counters and result register.
`default_nettype none
module bnis_dp #(
  parameter int MAX_BOXES = bnis_pkg::MAX_BOXES_DEF,
  parameter int DIM_WIDTH = bnis_pkg::DIM_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [bnis_pkg::DIM_IN_W-1:0]     dim_a,
  input  wire logic [bnis_pkg::DIM_IN_W-1:0]     dim_b,
  input  wire logic [bnis_pkg::DIM_IN_W-1:0]     dim_c,
  input  wire logic                              last_box,
  input  wire bnis_pkg::cmd_t                    cmd,
  output bnis_pkg::sts_t                         sts,
  output logic      [bnis_pkg::NUM_OUT_W-1:0]    box_number,
  output logic                                   final_result,
  output logic                                   overflow
);
  import bnis_pkg::*;

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int EW = AW + 3 * DIM_WIDTH;

  // strict fit of p inside q under any of the six rotations of q
  function automatic logic fits_inside(
    input logic [DIM_WIDTH-1:0] a, input logic [DIM_WIDTH-1:0] b,
    input logic [DIM_WIDTH-1:0] c, input logic [DIM_WIDTH-1:0] x,
    input logic [DIM_WIDTH-1:0] y, input logic [DIM_WIDTH-1:0] z);
    return (a < x && b < y && c < z) || (a < z && b < x && c < y) ||
           (a < y && b < z && c < x) || (a < z && b < y && c < x) ||
           (a < x && b < z && c < y) || (a < y && b < x && c < z);
  endfunction

  // New box being inserted
  logic [AW-1:0]        nb_num;
  logic [DIM_WIDTH-1:0] nb_d0, nb_d1, nb_d2;
  logic                 last;

  // Run bookkeeping
  logic [CW-1:0] count;
  logic          overflow_seen;
  logic [AW-1:0] pos;
  logic [AW-1:0] k;

  // Storage port signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [AW-1:0]        rd_num;
  logic [DIM_WIDTH-1:0] rd_d0, rd_d1, rd_d2;

  assign {rd_num, rd_d0, rd_d1, rd_d2} = rdata;

  // Latch the new box and track count/overflow
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      nb_num <= count[AW-1:0];
      nb_d0  <= DIM_WIDTH'(dim_a);
      nb_d1  <= DIM_WIDTH'(dim_b);
      nb_d2  <= DIM_WIDTH'(dim_c);
      last   <= last_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      pos           <= '0;
      k             <= '0;
    end else begin
      if (cmd.take) begin
        if (sts.full) begin
          overflow_seen <= 1'b1;
        end else begin
          pos <= count[AW-1:0];
        end
      end
      if (cmd.shift) begin
        pos <= pos - 1'b1;
      end
      if (cmd.place) begin
        count <= count + 1'b1;
      end
      if (cmd.emit_next) begin
        k <= k + 1'b1;
      end
      if (cmd.run_clr) begin
        count         <= '0;
        overflow_seen <= 1'b0;
        k             <= '0;
      end
    end
  end

  // Storage access: shift moves the entry below up, place drops in the new box
  assign we    = cmd.shift || cmd.place;
  assign waddr = pos;
  assign wdata = cmd.shift ? rdata : {nb_num, nb_d0, nb_d1, nb_d2};
  assign raddr = cmd.emit_rd ? k : pos - 1'b1;

  bnis_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      box_number   <= NUM_OUT_W'(rd_num);
      final_result <= sts.emit_end;
      overflow     <= overflow_seen;
    end
  end

  // Status to the controller
  always_comb begin
    sts.full     = (count == CW'(MAX_BOXES));
    sts.cnt_zero = (count == '0);
    sts.pos_one  = (pos == AW'(1));
    sts.fits     = fits_inside(nb_d0, nb_d1, nb_d2, rd_d0, rd_d1, rd_d2);
    sts.last     = last;
    sts.in_last  = last_box;
    sts.emit_end = ((CW'(k) + CW'(1)) == count);
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_read_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_pos |-> pos != '0)
    else $error("read below the bottom of the list");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> pos != '0)
    else $error("shift below the bottom of the list");

  a_place_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> count == $past(count) + 1'b1)
    else $error("placed box not counted");

  a_run_clr: assert property (@(posedge clk) disable iff (rst)
    cmd.run_clr |=> count == '0 && !overflow_seen && k == '0)
    else $error("run state not cleared at end of run");

endmodule
`default_nettype wire

// ===== rtl/box_nesting_insertion_sort_top.sv =====
// Top level: box nesting insertion sorter, controller plus datapath.
//
//  Channel   Dir  Handshake      Payload
//  boxes     in   valid/ready    dim_a, dim_b, dim_c, last_box
//  results   out  valid/ready    box_number, final_result, overflow
//
// One box request at a time. A box is accepted; then each entry it is compared with
// is read from the list storage, compared and, if the new box fits inside it, moved
// up; last the new box is written. Entries are read one at a time through the single
// read port. A box that arrives while the list is full is dropped. After the last box
// each result is read, loaded into the result register and held until taken on
// results. No request is taken while results drain. Reset empties the list at once.
`default_nettype none
module box_nesting_insertion_sort_top #(
  parameter int MAX_BOXES = bnis_pkg::MAX_BOXES_DEF,
  parameter int DIM_WIDTH = bnis_pkg::DIM_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  bnis_box_if.sink   boxes,
  bnis_res_if.source results
);
  import bnis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bnis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (boxes.valid),
    .in_ready  (boxes.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bnis_dp #(
    .MAX_BOXES (MAX_BOXES),
    .DIM_WIDTH (DIM_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .dim_a        (boxes.dim_a),
    .dim_b        (boxes.dim_b),
    .dim_c        (boxes.dim_c),
    .last_box     (boxes.last_box),
    .cmd          (cmd),
    .sts          (sts),
    .box_number   (results.box_number),
    .final_result (results.final_result),
    .overflow     (results.overflow)
  );

endmodule
`default_nettype wire
